// ===== hdl/svc_pkg.sv =====
package svc_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ID_W     = 63;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;

  // Opcodes of an input beat
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ORDER = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Configuration register indexes
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic exec;   // evaluate the captured item
    logic rd;     // issue a list read at the probe midpoint
    logic cmp;    // compare the read entry and narrow the window
    logic emit;   // move the result into the output register
  } svc_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_search;  // query falls inside the bounds and the list is not empty
    logic search_last;  // this compare ends the search
    logic out_busy;     // output register holds a beat that is not taken this cycle
  } svc_stat_t;

endpackage

// ===== hdl/svc_ram.sv =====
module svc_ram #(
  parameter int unsigned WIDTH = 63,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                          clk,
  input  logic                                          wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                              wr_data,
  input  logic                                          rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                              rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/svc_dp.sv =====
module svc_dp #(
  parameter int unsigned MAX_RUNNING = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [71:0]                   in_tdata,
  input  logic                          out_tready,
  output logic                          out_tvalid,
  output logic [7:0]                    out_tdata,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_index,
  input  logic [svc_pkg::ID_W-1:0]      cfg_wr_data,
  input  svc_pkg::svc_cmd_t             cmd,
  output svc_pkg::svc_stat_t            stat
);

  localparam int unsigned CW = $clog2(MAX_RUNNING + 1);
  localparam int unsigned AW = (MAX_RUNNING > 1) ? $clog2(MAX_RUNNING) : 1;
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_RUNNING);

  // Configuration
  logic [svc_pkg::ID_W-1:0] lower_r;
  logic [svc_pkg::ID_W-1:0] upper_r;

  // Snapshot state
  logic [CW-1:0]            count_r;
  logic [svc_pkg::ID_W-1:0] prev_r;

  // Captured item
  logic [svc_pkg::OP_W-1:0] op_r;
  logic [svc_pkg::ID_W-1:0] id_r;

  // Search window
  logic [CW-1:0] lo_r;
  logic [CW-1:0] hi_r;
  logic [CW-1:0] mid_r;

  // Pending result
  logic                         res_vis_r;
  logic [svc_pkg::STATUS_W-1:0] res_st_r;

  // Output register
  logic                         out_valid_r;
  logic                         out_vis_r;
  logic [svc_pkg::STATUS_W-1:0] out_st_r;

  logic                     id_lt_lower;
  logic                     id_ge_upper;
  logic                     id_le_prev;
  logic                     list_full;
  logic                     app_ok;
  logic [CW-1:0]            mid;
  logic [svc_pkg::ID_W-1:0] ram_rd_data;
  logic                     ent_eq;
  logic                     ent_lt;
  logic [CW-1:0]            lo_nxt;
  logic [CW-1:0]            hi_nxt;

  // Window and list checks on the captured id
  assign id_lt_lower = id_r < lower_r;
  assign id_ge_upper = id_r >= upper_r;
  assign id_le_prev  = id_r <= prev_r;
  assign list_full   = count_r >= COUNT_MAX;
  assign app_ok      = (op_r == svc_pkg::OP_APPEND) && !id_le_prev && !id_lt_lower &&
                       !id_ge_upper && !list_full;

  // Probe midpoint and window update
  assign mid    = lo_r + ((hi_r - lo_r) >> 1);
  assign ent_eq = ram_rd_data == id_r;
  assign ent_lt = ram_rd_data < id_r;
  assign lo_nxt = ent_lt ? (mid_r + CW'(1)) : lo_r;
  assign hi_nxt = (!ent_lt && !ent_eq) ? mid_r : hi_r;

  assign stat.need_search = (op_r == svc_pkg::OP_QUERY) && !id_lt_lower && !id_ge_upper &&
                            (count_r != '0);
  assign stat.search_last = ent_eq || (lo_nxt >= hi_nxt);
  assign stat.out_busy    = out_valid_r && !out_tready;

  svc_ram #(
    .WIDTH (svc_pkg::ID_W),
    .DEPTH (MAX_RUNNING)
  ) u_list (
    .clk     (clk),
    .wr_en   (cmd.exec && app_ok),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (id_r),
    .rd_en   (cmd.rd),
    .rd_addr (mid[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= svc_pkg::ID_W'(1);
      upper_r <= svc_pkg::ID_W'(1);
    end else if (cfg_wr_en) begin
      if (cfg_index == svc_pkg::REG_LOWER) begin
        lower_r <= cfg_wr_data;
      end else begin
        upper_r <= cfg_wr_data;
      end
    end
  end

  // List count and last accepted id
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= '0;
    end else if (cmd.exec) begin
      if (op_r == svc_pkg::OP_CLEAR) begin
        count_r <= '0;
        prev_r  <= '0;
      end else if (app_ok) begin
        count_r <= count_r + CW'(1);
        prev_r  <= id_r;
      end
    end
  end

  // Capture item, evaluate, and step the search
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_tdata[svc_pkg::OP_W-1:0];
      id_r <= in_tdata[svc_pkg::OP_W +: svc_pkg::ID_W];
    end
    if (cmd.exec) begin
      lo_r      <= '0;
      hi_r      <= count_r;
      res_vis_r <= 1'b0;
      res_st_r  <= svc_pkg::ST_OK;
      case (op_r)
        svc_pkg::OP_APPEND: begin
          if (id_le_prev || id_lt_lower || id_ge_upper) begin
            res_st_r <= svc_pkg::ST_ORDER;
          end else if (list_full) begin
            res_st_r <= svc_pkg::ST_FULL;
          end
        end
        svc_pkg::OP_QUERY: begin
          res_vis_r <= id_lt_lower || (!id_ge_upper && (count_r == '0));
        end
        default: begin
        end
      endcase
    end
    if (cmd.rd) begin
      mid_r <= mid;
    end
    if (cmd.cmp) begin
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      res_vis_r <= !ent_eq;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_vis_r <= res_vis_r;
      out_st_r  <= res_st_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_st_r, out_vis_r};

  // The list never grows past its capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("list count above capacity");

  // A probe is only issued into a non-empty window inside the list
  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> (lo_r < hi_r) && (hi_r <= count_r))
    else $error("probe outside the list");

  // A new result never overwrites a beat that is still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !(out_valid_r && !out_tready))
    else $error("result overwrites a pending beat");

endmodule

// ===== hdl/svc_ctrl.sv =====
module svc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  svc_pkg::svc_stat_t stat,
  output svc_pkg::svc_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_CMP  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = stat.need_search ? S_RD : S_EMIT;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = stat.search_last ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = state_r == S_IDLE;

  // An accepted beat is evaluated in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_EXEC))
    else $error("accepted beat not evaluated");

endmodule

// ===== hdl/snapshot_visibility_check_core.sv =====
// Snapshot visibility checker. Holds one transaction snapshot (lower and upper
// bound registers plus a sorted list of in-progress ids in a single-port-read
// RAM) and answers one result beat per input beat: clear the list, append an
// id (status 1 when not strictly ascending or outside [lower, upper), status 2
// when the list is full), or test an id for visibility. Clear, append and
// queries that fall outside the bounds or meet an empty list go from accept
// through evaluation straight to the result. A query inside the bounds
// binary-searches the list: each probe is a RAM read, then a compare, with
// probes at most ceil(log2(count + 1)). One item is in flight at a time; the
// next beat is taken as soon as the result sits in the output register, even
// if that beat has not been drained yet. Write the bounds only while idle.
module snapshot_visibility_check_core #(
  parameter int unsigned MAX_RUNNING = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,     // [1:0] opcode, [64:2] id_value, [71:65] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // [0] visible, [2:1] status, [7:3] zero
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [62:0] cfg_wr_data
);

  svc_pkg::svc_cmd_t  cmd;
  svc_pkg::svc_stat_t stat;

  svc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  svc_dp #(
    .MAX_RUNNING (MAX_RUNNING)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

endmodule
